[hdl/docd_pkg.sv]
`timescale 1ns / 1ps

package docd_pkg;

  // Years are carried with a bias so that every day count stays positive.
  localparam int unsigned YEAR_BIAS = 8000;
  localparam logic [12:0] YEAR_WRAP = 13'(8192 - YEAR_BIAS);

  // Days in one 400-year Gregorian cycle.
  localparam logic [17:0] DAYS_PER_ERA = 18'd146097;

  // Reciprocals for division by constants: floor(2^shift / divisor).
  // The quotient estimate is exact or one low and gets one correction step.
  localparam int unsigned SHIFT_400  = 24;
  localparam int unsigned SHIFT_ERA  = 40;
  localparam int unsigned SHIFT_1460 = 28;
  localparam int unsigned SHIFT_365  = 28;
  localparam logic [15:0] RECIP_400  = 16'((64'd1 << SHIFT_400) / 64'd400);
  localparam logic [22:0] RECIP_ERA  = 23'((64'd1 << SHIFT_ERA) / 64'd146097);
  localparam logic [17:0] RECIP_1460 = 18'((64'd1 << SHIFT_1460) / 64'd1460);
  localparam logic [19:0] RECIP_365  = 20'((64'd1 << SHIFT_365) / 64'd365);

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_EPOCH_DAY   = 2'd0,
    REG_EPOCH_MONTH = 2'd1,
    REG_EPOCH_YEAR  = 2'd2
  } cfg_reg_t;

  // Era number and day within the era of a serial day.
  typedef struct packed {
    logic [5:0]  era;
    logic [17:0] doe;
  } era_word_t;

  // Biased March-based year and day within that year.
  typedef struct packed {
    logic [13:0] year_base;
    logic [8:0]  doy;
  } yday_t;

  // Finished calendar date.
  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [12:0] year;
  } date_t;

  // Day of the March-based year on which a month starts. A month code of
  // zero counts as January and codes above twelve count as December.
  function automatic logic [8:0] epoch_month_doy(input logic [3:0] month);
    logic [8:0] doy;
    case (month)
      4'd0, 4'd1: doy = 9'd306;
      4'd2:       doy = 9'd337;
      4'd3:       doy = 9'd0;
      4'd4:       doy = 9'd31;
      4'd5:       doy = 9'd61;
      4'd6:       doy = 9'd92;
      4'd7:       doy = 9'd122;
      4'd8:       doy = 9'd153;
      4'd9:       doy = 9'd184;
      4'd10:      doy = 9'd214;
      4'd11:      doy = 9'd245;
      default:    doy = 9'd275;
    endcase
    return doy;
  endfunction

  // Start day of month index mp, where index 0 is March.
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] doy;
    case (mp)
      4'd0:    doy = 9'd0;
      4'd1:    doy = 9'd31;
      4'd2:    doy = 9'd61;
      4'd3:    doy = 9'd92;
      4'd4:    doy = 9'd122;
      4'd5:    doy = 9'd153;
      4'd6:    doy = 9'd184;
      4'd7:    doy = 9'd214;
      4'd8:    doy = 9'd245;
      4'd9:    doy = 9'd275;
      4'd10:   doy = 9'd306;
      4'd11:   doy = 9'd337;
      default: doy = 9'd0;
    endcase
    return doy;
  endfunction

  // Number of whole centuries in a year of era (below 400).
  function automatic logic [1:0] centuries(input logic [8:0] yoe);
    return 2'(yoe >= 9'd100) + 2'(yoe >= 9'd200) + 2'(yoe >= 9'd300);
  endfunction

endpackage

[hdl/docd_serial.sv]
`timescale 1ns / 1ps

module docd_serial (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic signed [19:0] day_offset,
  input  logic [4:0]         epoch_day,
  input  logic [3:0]         epoch_month,
  input  logic [11:0]        epoch_year,
  output logic               out_valid,
  output logic [22:0]        serial
);
  import docd_pkg::*;

  logic [4:0] valid;

  logic signed [19:0] off1, off2, off3, off4;
  logic [4:0]         day1, day2, day3, day4;
  logic [8:0]         mdoy1, mdoy2, mdoy3;
  logic [13:0]        year1, year2;
  logic [4:0]         q2;
  logic [4:0]         era3;
  logic [8:0]         yoe3;
  logic [22:0]        base4;
  logic [17:0]        doe4;
  logic [22:0]        serial5;

  logic [29:0]        prod400;
  logic [13:0]        rem400;
  logic signed [24:0] sum5;

  // Valid bits travel with the word.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[3:0], in_valid};
    end
  end

  // Stage 1: biased year of the month start, shifted back for Jan and Feb.
  always_ff @(posedge clk) begin
    off1  <= day_offset;
    day1  <= epoch_day;
    mdoy1 <= epoch_month_doy(epoch_month);
    year1 <= 14'(epoch_year) + 14'(YEAR_BIAS) - 14'(epoch_month <= 4'd2);
  end

  // Stage 2: era estimate by reciprocal multiply.
  assign prod400 = 30'(year1) * 30'(RECIP_400);

  always_ff @(posedge clk) begin
    off2  <= off1;
    day2  <= day1;
    mdoy2 <= mdoy1;
    year2 <= year1;
    q2    <= prod400[SHIFT_400+4:SHIFT_400];
  end

  // Stage 3: correct the era and take the year of era.
  assign rem400 = year2 - 14'(q2) * 14'd400;

  always_ff @(posedge clk) begin
    off3  <= off2;
    day3  <= day2;
    mdoy3 <= mdoy2;
    if (rem400 >= 14'd400) begin
      era3 <= q2 + 5'd1;
      yoe3 <= 9'(rem400 - 14'd400);
    end else begin
      era3 <= q2;
      yoe3 <= 9'(rem400);
    end
  end

  // Stage 4: days before the era and days within the era.
  always_ff @(posedge clk) begin
    off4  <= off3;
    day4  <= day3;
    base4 <= 23'(era3) * 23'(DAYS_PER_ERA);
    doe4  <= 18'(yoe3) * 18'd365 + 18'(yoe3 >> 2) - 18'(centuries(yoe3))
             + 18'(mdoy3);
  end

  // Stage 5: add the epoch day and the offset; the sum is always positive.
  assign sum5 = $signed({2'b00, base4}) + $signed({7'b0, doe4})
              + $signed({20'b0, day4}) - 25'sd1 + 25'(off4);

  always_ff @(posedge clk) begin
    serial5 <= sum5[22:0];
  end

  assign out_valid = valid[4];
  assign serial    = serial5;

endmodule

[hdl/docd_era.sv]
`timescale 1ns / 1ps

module docd_era (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic [22:0]               serial,
  output logic                      out_valid,
  output docd_pkg::era_word_t       out_word
);
  import docd_pkg::*;

  logic [1:0]  valid;
  logic [22:0] serial6;
  logic [5:0]  q6;
  era_word_t   word7;

  logic [45:0] prod_era;
  logic [22:0] rem_era;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[0], in_valid};
    end
  end

  // Stage 6: era estimate by reciprocal multiply.
  assign prod_era = 46'(serial) * 46'(RECIP_ERA);

  always_ff @(posedge clk) begin
    serial6 <= serial;
    q6      <= prod_era[SHIFT_ERA+5:SHIFT_ERA];
  end

  // Stage 7: correct the era and keep the day of era.
  assign rem_era = serial6 - 23'(q6) * 23'(DAYS_PER_ERA);

  always_ff @(posedge clk) begin
    if (rem_era >= 23'(DAYS_PER_ERA)) begin
      word7.era <= q6 + 6'd1;
      word7.doe <= 18'(rem_era - 23'(DAYS_PER_ERA));
    end else begin
      word7.era <= q6;
      word7.doe <= 18'(rem_era);
    end
  end

  assign out_valid = valid[1];
  assign out_word  = word7;

endmodule

[hdl/docd_year.sv]
`timescale 1ns / 1ps

module docd_year (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  docd_pkg::era_word_t   in_word,
  output logic                  out_valid,
  output docd_pkg::yday_t       out_word
);
  import docd_pkg::*;

  logic [5:0] valid;

  era_word_t  w8, w9, w10, w11, w12;
  logic [6:0] q8, q9;
  logic [2:0] cent8, cent9;
  logic       last8, last9;
  logic [17:0] x10, x11;
  logic [8:0]  yq11, yoe12;
  yday_t       word13;

  logic [35:0] prod1460;
  logic [17:0] rem1460;
  logic [37:0] prod365;
  logic [17:0] rem365;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[4:0], in_valid};
    end
  end

  // Stage 8: leap-day count estimate and the century corrections.
  assign prod1460 = 36'(in_word.doe) * 36'(RECIP_1460);

  always_ff @(posedge clk) begin
    w8    <= in_word;
    q8    <= prod1460[SHIFT_1460+6:SHIFT_1460];
    cent8 <= 3'(in_word.doe >= 18'd36524) + 3'(in_word.doe >= 18'd73048)
           + 3'(in_word.doe >= 18'd109572) + 3'(in_word.doe >= 18'd146096);
    last8 <= in_word.doe >= 18'd146096;
  end

  // Stage 9: correct the leap-day count.
  assign rem1460 = w8.doe - 18'(q8) * 18'd1460;

  always_ff @(posedge clk) begin
    w9    <= w8;
    cent9 <= cent8;
    last9 <= last8;
    q9    <= (rem1460 >= 18'd1460) ? q8 + 7'd1 : q8;
  end

  // Stage 10: day of era with leap days taken out.
  always_ff @(posedge clk) begin
    w10 <= w9;
    x10 <= w9.doe - 18'(q9) + 18'(cent9) - 18'(last9);
  end

  // Stage 11: year of era estimate.
  assign prod365 = 38'(x10) * 38'(RECIP_365);

  always_ff @(posedge clk) begin
    w11  <= w10;
    x11  <= x10;
    yq11 <= prod365[SHIFT_365+8:SHIFT_365];
  end

  // Stage 12: correct the year of era.
  assign rem365 = x11 - 18'(yq11) * 18'd365;

  always_ff @(posedge clk) begin
    w12   <= w11;
    yoe12 <= (rem365 >= 18'd365) ? yq11 + 9'd1 : yq11;
  end

  // Stage 13: day of year and biased year.
  always_ff @(posedge clk) begin
    word13.doy       <= 9'(w12.doe - (18'(yoe12) * 18'd365 + 18'(yoe12 >> 2)
                        - 18'(centuries(yoe12))));
    word13.year_base <= 14'(w12.era) * 14'd400 + 14'(yoe12);
  end

  assign out_valid = valid[5];
  assign out_word  = word13;

endmodule

[hdl/docd_month.sv]
`timescale 1ns / 1ps

module docd_month (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  docd_pkg::yday_t   in_word,
  output logic              out_valid,
  output docd_pkg::date_t   out_date
);
  import docd_pkg::*;

  logic [1:0] valid;
  yday_t      w14;
  logic [3:0] mp14;
  date_t      date15;
  logic [3:0] mp_count;
  logic [3:0] month15;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[0], in_valid};
    end
  end

  // Stage 14: month index from the month start table.
  always_comb begin
    mp_count = '0;
    for (int k = 1; k < 12; k++) begin
      mp_count = mp_count + 4'(in_word.doy >= month_start(4'(k)));
    end
  end

  always_ff @(posedge clk) begin
    w14  <= in_word;
    mp14 <= mp_count;
  end

  // Stage 15: day, calendar month and unbiased year.
  assign month15 = (mp14 < 4'd10) ? mp14 + 4'd3 : mp14 - 4'd9;

  always_ff @(posedge clk) begin
    date15.day   <= 5'(w14.doy - month_start(mp14) + 9'd1);
    date15.month <= month15;
    date15.year  <= w14.year_base[12:0] + YEAR_WRAP + 13'(mp14 >= 4'd10);
  end

  assign out_valid = valid[1];
  assign out_date  = date15;

endmodule

[hdl/day_offset_to_calendar_date.sv]
`timescale 1ns / 1ps

// Converts a signed day offset into the Gregorian date that lies that many
// days from a programmable epoch (30 Dec 1899 after reset). The block is a
// 15-stage pipeline: a word is accepted at every clock edge where start is
// high, busy never rises, and each result appears on the result ports with
// done high for exactly one cycle, in the order of the starts. The pipeline
// holds four constant divisions (by 400, by the era length, by the four-year
// length and by the year length), each done as a reciprocal multiply
// followed by a one-step correction stage.
// The results cannot be held off, so the receiver must take every word in
// the cycle it is shown.
// The epoch registers may be written only while no conversion is in flight.
module day_offset_to_calendar_date (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [19:0] day_offset,
  input  logic               wr_en,
  input  logic [1:0]         wr_index,
  input  logic [11:0]        wr_data,
  output logic               done,
  output logic [4:0]         result_day,
  output logic [3:0]         result_month,
  output logic [12:0]        result_year
);
  import docd_pkg::*;

  localparam int unsigned PIPE_LATENCY = 15;
  localparam logic [3:0]  MONTH_FEB    = 4'd2;

  logic        accept;
  logic [4:0]  epoch_day;
  logic [3:0]  epoch_month;
  logic [11:0] epoch_year;

  logic        serial_valid;
  logic [22:0] serial;
  logic        era_valid;
  era_word_t   era_word;
  logic        yday_valid;
  yday_t       yday_word;
  date_t       date;

  // The pipeline takes a word every cycle.
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // Epoch registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      epoch_day   <= 5'd30;
      epoch_month <= 4'd12;
      epoch_year  <= 12'd1899;
    end else if (wr_en) begin
      unique case (cfg_reg_t'(wr_index))
        REG_EPOCH_DAY:   epoch_day   <= wr_data[4:0];
        REG_EPOCH_MONTH: epoch_month <= wr_data[3:0];
        REG_EPOCH_YEAR:  epoch_year  <= wr_data;
        default: ;
      endcase
    end
  end

  // Epoch plus offset to serial day.
  docd_serial u_serial (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (accept),
    .day_offset  (day_offset),
    .epoch_day   (epoch_day),
    .epoch_month (epoch_month),
    .epoch_year  (epoch_year),
    .out_valid   (serial_valid),
    .serial      (serial)
  );

  // Serial day to era and day of era.
  docd_era u_era (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (serial_valid),
    .serial    (serial),
    .out_valid (era_valid),
    .out_word  (era_word)
  );

  // Day of era to year and day of year.
  docd_year u_year (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (era_valid),
    .in_word   (era_word),
    .out_valid (yday_valid),
    .out_word  (yday_word)
  );

  // Day of year to month and day.
  docd_month u_month (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (yday_valid),
    .in_word   (yday_word),
    .out_valid (done),
    .out_date  (date)
  );

  assign result_day   = date.day;
  assign result_month = date.month;
  assign result_year  = date.year;

  // Every result comes from a word started a fixed time before.
  assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, PIPE_LATENCY))
    else $error("result without a matching start");

  // Day and month fields stay in their calendar ranges.
  assert property (@(posedge clk) disable iff (rst)
    done |-> (result_day >= 5'd1 && result_month >= 4'd1 && result_month <= 4'd12))
    else $error("date field out of range");

  // February never runs past its leap day.
  assert property (@(posedge clk) disable iff (rst)
    (done && result_month == MONTH_FEB) |-> result_day <= 5'd29)
    else $error("February day beyond 29");

endmodule
